@@ hdl/htd_pkg.sv @@
// ---------------------------------------------------------------------------
// htd_pkg
// shared types and constants of the huffman tree deserializer
// ---------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

  localparam int unsigned MAX_LEAVES_DEF = 256;
  localparam int unsigned CFG_W          = 9;
  localparam int unsigned IDX_W          = 9;
  localparam int unsigned SYM_W          = 8;

  localparam logic MODE_JOIN = 1'b0;
  localparam logic MODE_LEAF = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_FINISHED  = 2'd3
  } err_e;

  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] node_index;
    logic             is_leaf;
    logic [SYM_W-1:0] leaf_symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic             done_res;
    logic [IDX_W-1:0] root_index;
    err_e             error_code;
  } out_t;

endpackage

`default_nettype wire

@@ hdl/htd_ram.sv @@
// ---------------------------------------------------------------------------
// htd_ram
// node stack storage, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module htd_ram #(
  parameter int unsigned DEPTH = htd_pkg::MAX_LEAVES_DEF,
  parameter int unsigned WIDTH = htd_pkg::IDX_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/huffman_tree_deserializer.sv @@
// ---------------------------------------------------------------------------
// huffman_tree_deserializer
// rebuilds a huffman code tree from its post-order serialization
// ---------------------------------------------------------------------------
//   channel | signals                          | transfer when
//   in      | in_valid_i, in_stall_o, in_data_i | in_valid_i & !in_stall_o
//   out     | out_valid_o, out_stall_i, out_data_o | out_valid_o & !out_stall_i
//   cfg     | cfg_we_i, cfg_wdata_i            | cfg_we_i
//
// one item per cycle; its node record appears in the output register the
// cycle after the transfer. the top two stack entries and the third sit in
// registers; the rest live in a ram, read on each join to refill the third.
// input stalls only while the output register holds a record that is stalled.
// reset and a leaf_count write restart decoding at once, no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module huffman_tree_deserializer #(
  parameter int unsigned MAX_LEAVES = htd_pkg::MAX_LEAVES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire htd_pkg::in_t              in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output htd_pkg::out_t                  out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [htd_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned SW = $clog2(MAX_LEAVES + 1);
  localparam int unsigned AW = $clog2(MAX_LEAVES);
  localparam int unsigned NW = $clog2(2 * MAX_LEAVES);
  localparam int unsigned CW = (NW > htd_pkg::CFG_W) ? NW : htd_pkg::CFG_W;
  localparam logic [NW-1:0] NODE_CAP = NW'(2 * MAX_LEAVES - 1);
  localparam logic [SW-1:0] STACK_CAP = SW'(MAX_LEAVES);

  logic [htd_pkg::CFG_W-1:0] leaf_count_q;
  logic [SW-1:0]             size_q, size_d;
  logic [NW-1:0]             next_q, next_d;
  logic [NW-1:0]             leaves_q, leaves_d;
  logic                      fin_q, fin_d;
  logic [NW-1:0]             top_q, top_d;
  logic [NW-1:0]             sec_q, sec_d;
  logic [NW-1:0]             third_q, third_d;
  logic                      sel_mem_q, sel_mem_d;
  logic [NW-1:0]             third_cur;
  logic                      out_valid_q;
  htd_pkg::out_t             out_q, res_d;
  logic                      accept;
  logic                      push_ok;
  logic                      join_ok;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  logic [NW-1:0]             ram_rdata;
  logic [CW-1:0]             target;
  htd_pkg::err_e             err;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign third_cur   = sel_mem_q ? ram_rdata : third_q;

  always_comb begin
    if (leaf_count_q == '0) begin
      target = CW'(1);
    end else if (CW'(leaf_count_q) > CW'(MAX_LEAVES)) begin
      target = CW'(MAX_LEAVES);
    end else begin
      target = CW'(leaf_count_q);
    end
  end

  always_comb begin
    err = htd_pkg::ERR_OK;
    priority if (fin_q) begin
      err = htd_pkg::ERR_FINISHED;
    end else if (next_q >= NODE_CAP) begin
      err = htd_pkg::ERR_OVERFLOW;
    end else if (in_data_i.mode == htd_pkg::MODE_LEAF) begin
      if (size_q >= STACK_CAP) begin
        err = htd_pkg::ERR_OVERFLOW;
      end
    end else if (size_q < SW'(2)) begin
      err = htd_pkg::ERR_UNDERFLOW;
    end else begin
      err = htd_pkg::ERR_OK;
    end
  end

  assign push_ok = accept & (err == htd_pkg::ERR_OK) & (in_data_i.mode == htd_pkg::MODE_LEAF);
  assign join_ok = accept & (err == htd_pkg::ERR_OK) & (in_data_i.mode == htd_pkg::MODE_JOIN);

  always_comb begin
    size_d    = size_q;
    next_d    = next_q;
    leaves_d  = leaves_q;
    fin_d     = fin_q;
    top_d     = top_q;
    sec_d     = sec_q;
    third_d   = third_cur;
    sel_mem_d = 1'b0;
    ram_we    = push_ok | join_ok;
    ram_waddr = AW'(size_q);
    ram_raddr = AW'(size_q - SW'(4));
    if (push_ok) begin
      size_d   = size_q + SW'(1);
      next_d   = next_q + NW'(1);
      leaves_d = leaves_q + NW'(1);
      top_d    = next_q;
      sec_d    = top_q;
      third_d  = sec_q;
    end else if (join_ok) begin
      size_d    = size_q - SW'(1);
      next_d    = next_q + NW'(1);
      top_d     = next_q;
      sec_d     = third_cur;
      sel_mem_d = 1'b1;
      ram_waddr = AW'(size_q - SW'(2));
    end
    if (accept && !fin_q && err == htd_pkg::ERR_OK
        && CW'(leaves_d) >= target && size_d == SW'(1)) begin
      fin_d = 1'b1;
    end
  end

  always_comb begin
    res_d             = '0;
    res_d.error_code  = err;
    if (push_ok) begin
      res_d.node_index  = htd_pkg::IDX_W'(next_q);
      res_d.is_leaf     = 1'b1;
      res_d.leaf_symbol = in_data_i.symbol;
    end else if (join_ok) begin
      res_d.node_index  = htd_pkg::IDX_W'(next_q);
      res_d.left_child  = htd_pkg::IDX_W'(sec_q);
      res_d.right_child = htd_pkg::IDX_W'(top_q);
    end
    res_d.done_res = fin_d;
    if (fin_d) begin
      res_d.root_index = htd_pkg::IDX_W'(top_d);
    end
  end

  htd_ram #(
    .DEPTH (MAX_LEAVES),
    .WIDTH (NW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (next_q),
    .re_i    (join_ok),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= htd_pkg::CFG_W'(1);
      size_q       <= '0;
      next_q       <= '0;
      leaves_q     <= '0;
      fin_q        <= 1'b0;
      sel_mem_q    <= 1'b0;
    end else if (cfg_we_i) begin
      leaf_count_q <= cfg_wdata_i;
      size_q       <= '0;
      next_q       <= '0;
      leaves_q     <= '0;
      fin_q        <= 1'b0;
      sel_mem_q    <= 1'b0;
    end else begin
      size_q    <= size_d;
      next_q    <= next_d;
      leaves_q  <= leaves_d;
      fin_q     <= fin_d;
      sel_mem_q <= sel_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    sec_q   <= sec_d;
    third_q <= third_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res_d;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// regression for the huffman tree deserializer: a short table of directed
// transfers, then random post-order trees with broken items mixed in and
// long sequences that run into the stack and node limits. every node record
// is checked field by field against the table's expected record or a
// behavioral tree builder; the random trees run under mixes of gaps and stalls.
// ---------------------------------------------------------------------------

module tb_top;
  import htd_pkg::*;

  localparam int unsigned MAX         = MAX_LEAVES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 50;
  localparam int          IDLE_PCT [4] = '{0, 45, 0, 19};
  localparam int          STALL_PCT[4] = '{0, 0, 45, 19};

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CFG_W-1:0] cfg;
    in_t              item;
    logic             has_lit;
    out_t             lit;
  } row_t;

  localparam out_t NO_RESULT = '0;
  localparam int   N_ROWS    = 25;

  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b1,
      '{9'd0, 1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 9'd0, ERR_UNDERFLOW}},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'hff}, 1'b1,
      '{9'd0, 1'b1, 8'hff, 9'd0, 9'd0, 1'b1, 9'd0, ERR_OK}},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h00}, 1'b1,
      '{9'd0, 1'b0, 8'h00, 9'd0, 9'd0, 1'b1, 9'd0, ERR_FINISHED}},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b1,
      '{9'd0, 1'b0, 8'h00, 9'd0, 9'd0, 1'b1, 9'd0, ERR_FINISHED}},
    '{ROW_CFG,  9'd0, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h00}, 1'b1,
      '{9'd0, 1'b1, 8'h00, 9'd0, 9'd0, 1'b1, 9'd0, ERR_OK}},
    '{ROW_CFG,  9'd3, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'ha5}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'hff}, 1'b1,
      '{9'd0, 1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 9'd0, ERR_UNDERFLOW}},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h5a}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h3c}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'hc3}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h81}, 1'b0, NO_RESULT},
    '{ROW_CFG,  9'h1ff, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h7e}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h01}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b1,
      '{9'd0, 1'b0, 8'h00, 9'd0, 9'd0, 1'b0, 9'd0, ERR_UNDERFLOW}},
    '{ROW_CFG,  9'd2, '{MODE_JOIN, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h80}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_LEAF, 8'h7f}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 9'd0, '{MODE_JOIN, 8'h00}, 1'b1,
      '{9'd2, 1'b0, 8'h00, 9'd0, 9'd1, 1'b1, 9'd2, ERR_OK}}
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  huffman_tree_deserializer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // tree builder state
  logic [IDX_W-1:0] node_stk [MAX];
  int unsigned      stk_depth;
  int unsigned      next_idx;
  int unsigned      leaf_total;
  bit               tree_done;
  logic [CFG_W-1:0] leaf_cfg;

  out_t        node_q[$];
  int          fail_cnt   = 0;
  int          item_cnt   = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int unsigned cycle_cnt  = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("huffman_tree_deserializer regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic void restart_tree(logic [CFG_W-1:0] v);
    leaf_cfg   = v;
    stk_depth  = 0;
    next_idx   = 0;
    leaf_total = 0;
    tree_done  = 1'b0;
  endfunction

  function automatic out_t build_node(in_t it);
    out_t        r;
    int unsigned target;
    r = '0;
    target = (leaf_cfg == 0) ? 1 : (leaf_cfg > MAX) ? MAX : leaf_cfg;
    if (tree_done) begin
      r.error_code = ERR_FINISHED;
    end else if (next_idx >= 2 * MAX - 1) begin
      r.error_code = ERR_OVERFLOW;
    end else if (it.mode == MODE_LEAF) begin
      if (stk_depth >= MAX) begin
        r.error_code = ERR_OVERFLOW;
      end else begin
        r.node_index  = next_idx[IDX_W-1:0];
        r.is_leaf     = 1'b1;
        r.leaf_symbol = it.symbol;
        node_stk[stk_depth] = next_idx[IDX_W-1:0];
        stk_depth++;
        next_idx++;
        leaf_total++;
      end
    end else if (stk_depth < 2) begin
      r.error_code = ERR_UNDERFLOW;
    end else begin
      r.right_child = node_stk[stk_depth-1];
      r.left_child  = node_stk[stk_depth-2];
      r.node_index  = next_idx[IDX_W-1:0];
      stk_depth--;
      node_stk[stk_depth-1] = next_idx[IDX_W-1:0];
      next_idx++;
    end
    if (!tree_done && r.error_code == ERR_OK && leaf_total >= target && stk_depth == 1)
      tree_done = 1'b1;
    if (tree_done) begin
      r.done_res   = 1'b1;
      r.root_index = node_stk[0];
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : node_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (node_q.size() == 0) begin
        $error("node record transfer with none expected");
        fail_cnt++;
      end else begin
        want = node_q.pop_front();
        check_field("node_index", want.node_index, out_data_o.node_index);
        check_field("is_leaf", want.is_leaf, out_data_o.is_leaf);
        check_field("leaf_symbol", want.leaf_symbol, out_data_o.leaf_symbol);
        check_field("left_child", want.left_child, out_data_o.left_child);
        check_field("right_child", want.right_child, out_data_o.right_child);
        check_field("done_res", want.done_res, out_data_o.done_res);
        check_field("root_index", want.root_index, out_data_o.root_index);
        check_field("error_code", want.error_code, out_data_o.error_code);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input in_t it, input bit has_lit, input out_t lit);
    out_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = build_node(it);
    node_q.push_back(has_lit ? lit : pred);
    item_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic m);
    in_t it;
    it.mode   = m;
    it.symbol = 8'($urandom_range(255));
    send_item(it, 1'b0, NO_RESULT);
  endtask

  task automatic load_leaf_count(input logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (node_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    restart_tree(v);
  endtask

  task automatic build_tree(input int n, input bit noisy);
    int               open_cnt;
    int               left_cnt;
    int               extra;
    logic [CFG_W-1:0] cfg_val;
    if (n == 1)
      cfg_val = CFG_W'($urandom_range(1));
    else if (n == MAX)
      cfg_val = CFG_W'($urandom_range(511, MAX));
    else
      cfg_val = CFG_W'(n);
    load_leaf_count(cfg_val);
    open_cnt = 0;
    left_cnt = n;
    while (!(left_cnt == 0 && open_cnt == 1)) begin
      if (noisy && $urandom_range(19) == 0) begin
        // broken item: a join that underflows, or else a leaf (extra once all are sent)
        if (open_cnt < 2) begin
          send_op(MODE_JOIN);
        end else begin
          send_op(MODE_LEAF);
          open_cnt++;
          if (left_cnt > 0) left_cnt--;
        end
      end else if (left_cnt > 0 && (open_cnt < 2 || $urandom_range(1) == 1)) begin
        send_op(MODE_LEAF);
        open_cnt++;
        left_cnt--;
      end else begin
        send_op(MODE_JOIN);
        open_cnt--;
      end
    end
    if (noisy) begin
      extra = $urandom_range(3);
      repeat (extra) send_op(1'($urandom_range(1)));
    end
  endtask

  initial begin
    int start_cnt;
    int n;
    restart_tree(9'd1);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG)
        load_leaf_count(DIRECTED[i].cfg);
      else
        send_item(DIRECTED[i].item, DIRECTED[i].has_lit, DIRECTED[i].lit);
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct  = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      start_cnt = item_cnt;
      while (item_cnt - start_cnt < PHASE_ITEMS) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        build_tree(n, $urandom_range(3) != 0);
      end
    end

    // stack full: one leaf past capacity
    load_leaf_count(9'h1ff);
    repeat (MAX + 1) send_op(MODE_LEAF);
    send_op(MODE_JOIN);

    // node limit: stack held at two or three entries until every index is used
    load_leaf_count(9'd256);
    send_op(MODE_LEAF);
    send_op(MODE_LEAF);
    repeat (MAX - 2) begin
      send_op(MODE_LEAF);
      send_op(MODE_JOIN);
    end
    send_op(MODE_LEAF);
    send_op(MODE_JOIN);
    send_op(MODE_LEAF);

    in_valid_i <= 1'b0;
    while (node_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("huffman_tree_deserializer regression: pass");
    else
      $display("huffman_tree_deserializer regression: fail");
    $finish;
  end

endmodule
